### hw/rtl/nlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nlc_pkg;

	localparam int MAX_PARTICLES = 32;
	localparam int FRAC_BITS     = 24;
	localparam int IDX_W         = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
	localparam int ACC_W         = 35;
	localparam int SUM_W         = 38;

	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_STEP   = 2'd1;
	localparam logic [1:0] FUNC_REPORT = 2'd2;

	localparam logic [2:0] REG_COUNT = 3'd0;
	localparam logic [2:0] REG_STEP  = 3'd1;
	localparam logic [2:0] REG_KOM   = 3'd2;
	localparam logic [2:0] REG_ALPHA = 3'd3;
	localparam logic [2:0] REG_BETA  = 3'd4;

	localparam logic [1:0] LAST_STAGE = 2'd3;

	typedef struct packed {
		logic signed [31:0]      x;
		logic signed [31:0]      v;
		logic signed [31:0]      lp;
		logic signed [31:0]      kp;
		logic signed [ACC_W-1:0] wx;
		logic signed [ACC_W-1:0] wv;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] h;
		logic signed [31:0] kom;
		logic signed [31:0] alpha;
		logic signed [31:0] beta;
	} coef_t;

	function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// trial value: base alone in stage 0, else base plus previous stage slope, halved except before the last stage
	function automatic logic signed [31:0] trial(input logic signed [31:0] base,
			input logic signed [31:0] sl, input logic [1:0] stage);
		logic signed [31:0] d;
		d = (stage == LAST_STAGE) ? sl : (sl >>> 1);
		if (stage == 2'd0) return base;
		return sat64(64'(base) + 64'(d));
	endfunction

endpackage
`default_nettype wire

### hw/rtl/nlc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module nlc_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire logic          load,
	input  wire logic [31:0]   load_x,
	input  wire logic [31:0]   load_v,
	input  wire nlc_pkg::cell_t shift_in,
	output nlc_pkg::cell_t     q
);
	import nlc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (shift) begin
			q <= shift_in;
		end else if (load) begin
			q.x <= load_x;
			q.v <= load_v;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/nlc_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module nlc_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           go,
	input  wire logic [1:0]     stage,
	input  wire logic           first,
	input  wire logic           has_right,
	input  wire nlc_pkg::cell_t head,
	input  wire nlc_pkg::cell_t nxt,
	input  wire nlc_pkg::coef_t coef,
	output logic                done,
	output nlc_pkg::cell_t      wb
);
	import nlc_pkg::*;

	typedef enum logic [5:0] {
		E_IDLE  = 6'b000001,
		E_SETUP = 6'b000010,
		E_MUL   = 6'b000100,
		E_SAT   = 6'b001000,
		E_ACC   = 6'b010000,
		E_DIV   = 6'b100000
	} est_t;

	localparam logic [3:0] OP_S1 = 4'd0, OP_S2 = 4'd1, OP_C2 = 4'd2, OP_C1 = 4'd3;
	localparam logic [3:0] OP_QA = 4'd4, OP_CB = 4'd5, OP_KM = 4'd6, OP_T = 4'd7;
	localparam logic [3:0] OP_LP = 4'd8;
	localparam int DIV_STEPS = 3;
	// floor(b/3) = (b * RECIP3) >> 36, exact for b below 2^34
	localparam int DIV_SHIFT = 36;
	localparam logic [34:0] RECIP3 = 35'd22906492246;

	est_t st_q;
	logic                 done_q;
	logic [3:0]           op_q;
	logic signed [31:0]   r_q [9];
	logic signed [31:0]   tx0_q, tx1_q, tx2_q, tv1_q, left_q;
	logic signed [63:0]   prod_q;
	logic signed [ACC_W-1:0] wx_q, wv_q;
	logic [ACC_W-1:0]     dqx_q, dqv_q;
	logic [51:0]          px_lo_q, pv_lo_q, px_hi_q, pv_hi_q;
	logic                 negx_q, negv_q;
	logic [1:0]           dcnt_q;

	logic signed [31:0] d1, d2, lin, sq, cu, inner, kp, opa, opb;
	logic signed [ACC_W-1:0] wx_n, wv_n, tlp, tkp;
	logic [68:0] qsx, qsv;
	logic signed [ACC_W:0] qx, qv;

	always_comb begin
		d1    = sat64(64'(tx1_q) - 64'(tx0_q));
		d2    = sat64(64'(tx2_q) - 64'(tx1_q));
		lin   = sat64(64'(tx1_q) + 64'(tx1_q) - 64'(tx0_q) - 64'(tx2_q));
		sq    = sat64(64'(r_q[OP_S2]) - 64'(r_q[OP_S1]));
		cu    = sat64(64'(r_q[OP_C2]) - 64'(r_q[OP_C1]));
		inner = sat64(64'(lin) - 64'(r_q[OP_QA]) - 64'(r_q[OP_CB]));
		kp    = sat64(-64'(r_q[OP_T]));
		case (op_q)
			OP_S1:   begin opa = d1;         opb = d1;    end
			OP_S2:   begin opa = d2;         opb = d2;    end
			OP_C2:   begin opa = r_q[OP_S2]; opb = d2;    end
			OP_C1:   begin opa = r_q[OP_S1]; opb = d1;    end
			OP_QA:   begin opa = coef.alpha; opb = sq;    end
			OP_CB:   begin opa = coef.beta;  opb = cu;    end
			OP_KM:   begin opa = coef.kom;   opb = inner; end
			OP_T:    begin opa = coef.h;     opb = r_q[OP_KM]; end
			OP_LP:   begin opa = coef.h;     opb = tv1_q; end
			default: begin opa = '0;         opb = '0;    end
		endcase
		// inner stages count twice in the RK4 weighted sum
		tlp = ACC_W'(r_q[OP_LP]);
		tkp = ACC_W'(kp);
		if (stage == 2'd1 || stage == 2'd2) begin
			tlp = tlp <<< 1;
			tkp = tkp <<< 1;
		end
		wx_n = ((stage == 2'd0) ? '0 : head.wx) + tlp;
		wv_n = ((stage == 2'd0) ? '0 : head.wv) + tkp;
		qsx = {px_hi_q, 17'd0} + 69'(px_lo_q);
		qsv = {pv_hi_q, 17'd0} + 69'(pv_lo_q);
		qx = negx_q ? -$signed({1'b0, dqx_q}) : $signed({1'b0, dqx_q});
		qv = negv_q ? -$signed({1'b0, dqv_q}) : $signed({1'b0, dqv_q});
		wb.lp = r_q[OP_LP];
		wb.kp = kp;
		wb.wx = wx_q;
		wb.wv = wv_q;
		if (stage == LAST_STAGE) begin
			wb.x = sat64(64'(head.x) + 64'(qx));
			wb.v = sat64(64'(head.v) + 64'(qv));
		end else begin
			wb.x = head.x;
			wb.v = head.v;
		end
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= E_IDLE;
			done_q <= 1'b0;
			op_q   <= '0;
			dcnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				E_IDLE: if (go && !done_q) st_q <= E_SETUP;
				E_SETUP: begin
					op_q <= OP_S1;
					st_q <= E_MUL;
				end
				E_MUL: st_q <= E_SAT;
				E_SAT: begin
					if (op_q == OP_LP) begin
						st_q <= E_ACC;
					end else begin
						op_q <= op_q + 4'd1;
						st_q <= E_MUL;
					end
				end
				E_ACC: begin
					dcnt_q <= '0;
					if (stage == LAST_STAGE) begin
						st_q <= E_DIV;
					end else begin
						done_q <= 1'b1;
						st_q   <= E_IDLE;
					end
				end
				E_DIV: begin
					dcnt_q <= dcnt_q + 2'd1;
					if (dcnt_q == 2'(DIV_STEPS - 1)) begin
						done_q <= 1'b1;
						st_q   <= E_IDLE;
					end
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == E_SETUP) begin
			tx0_q <= first ? 32'sd0 : left_q;
			tx1_q <= trial(head.x, head.lp, stage);
			tx2_q <= has_right ? trial(nxt.x, nxt.lp, stage) : 32'sd0;
			tv1_q <= trial(head.v, head.kp, stage);
		end
		if (st_q == E_MUL) prod_q <= 64'(opa) * 64'(opb);
		if (st_q == E_SAT) r_q[op_q] <= sat64(prod_q >>> FRAC_BITS);
		if (st_q == E_ACC) begin
			wx_q   <= wx_n;
			wv_q   <= wv_n;
			negx_q <= wx_n[ACC_W-1];
			negv_q <= wv_n[ACC_W-1];
			dqx_q  <= wx_n[ACC_W-1] ? ACC_W'(-wx_n) : ACC_W'(wx_n);
			dqv_q  <= wv_n[ACC_W-1] ? ACC_W'(-wv_n) : ACC_W'(wv_n);
			left_q <= tx1_q;
		end
		// magnitude / 6: halve, then split 17-bit halves through the reciprocal of 3
		if (st_q == E_DIV) begin
			if (dcnt_q == 2'd0) begin
				px_lo_q <= 52'(dqx_q[17:1]) * 52'(RECIP3);
				pv_lo_q <= 52'(dqv_q[17:1]) * 52'(RECIP3);
			end
			if (dcnt_q == 2'd1) begin
				px_hi_q <= 52'(dqx_q[ACC_W-1:18]) * 52'(RECIP3);
				pv_hi_q <= 52'(dqv_q[ACC_W-1:18]) * 52'(RECIP3);
			end
			if (dcnt_q == 2'd2) begin
				dqx_q <= ACC_W'(qsx[68:DIV_SHIFT]);
				dqv_q <= ACC_W'(qsv[68:DIV_SHIFT]);
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/nonlinear_chain_rk4_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Spring chain integrator, one RK4 step per command.
// Command channel: start with func, particle_index, load_position, load_velocity is
// taken when start is high and busy is low. Load writes one particle and gives
// no result. Report emits n results, one per cycle.
// Step runs four passes of the particle ring through one shared multiply engine:
// nine multiplies per active particle and pass, plus a reciprocal divide-by-six
// per particle in the last pass; idle ring slots are shifted past; then the emit pass.
// Results: strobe marks each result for one cycle, in index order; the last one
// carries last_particle and the sums. The receiver cannot stall.
// Config: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write only while idle.
// Reset clears all positions and velocities and restores register defaults.
module nonlinear_chain_rk4_step (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [1:0]          func,
	input  wire logic [4:0]          particle_index,
	input  wire logic signed [31:0]  load_position,
	input  wire logic signed [31:0]  load_velocity,
	output logic                     strobe,
	output logic [4:0]               out_index,
	output logic signed [31:0]       out_position,
	output logic signed [31:0]       out_velocity,
	output logic                     last_particle,
	output logic signed [37:0]       sum_position,
	output logic signed [37:0]       sum_velocity,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);
	import nlc_pkg::*;

	typedef enum logic [3:0] {
		T_IDLE  = 4'b0001,
		T_ISSUE = 4'b0010,
		T_WAIT  = 4'b0100,
		T_EMIT  = 4'b1000
	} tst_t;

	tst_t st_q;
	logic [5:0]  count_q;
	coef_t       coef_q;
	logic [IDX_W-1:0] idx_q;
	logic [1:0]  stage_q;
	logic signed [SUM_W-1:0] sp_q, sv_q;

	cell_t cell_q [MAX_PARTICLES];
	cell_t tail_in, wb;
	logic  shift, go, done, load_go, in_range, last_slot, is_last;
	logic [CNT_W-1:0] n;
	logic signed [SUM_W-1:0] sp_n, sv_n;

	always_comb begin
		if (count_q == '0) n = CNT_W'(1);
		else if (32'(count_q) > MAX_PARTICLES) n = CNT_W'(MAX_PARTICLES);
		else n = CNT_W'(count_q);
	end

	assign in_range  = CNT_W'(idx_q) < n;
	assign last_slot = idx_q == IDX_W'(MAX_PARTICLES - 1);
	assign is_last   = CNT_W'(idx_q) + CNT_W'(1) == n;
	assign load_go   = st_q == T_IDLE && start && func == FUNC_LOAD;
	assign go        = st_q == T_ISSUE && in_range;
	assign shift     = (st_q == T_ISSUE && !in_range) || (st_q == T_WAIT && done) ||
	                   st_q == T_EMIT;
	assign tail_in   = (st_q == T_WAIT) ? wb : cell_q[0];
	assign busy      = st_q != T_IDLE;
	assign cfg_ready = 1'b1;
	assign sp_n      = sp_q + SUM_W'(cell_q[0].x);
	assign sv_n      = sv_q + SUM_W'(cell_q[0].v);

	genvar k;
	generate
		for (k = 0; k < MAX_PARTICLES; k++) begin : g_cell
			cell_t sin;
			if (k == MAX_PARTICLES - 1) begin : g_tail
				assign sin = tail_in;
			end else begin : g_mid
				assign sin = cell_q[k+1];
			end
			nlc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.load     (load_go && 32'(particle_index) == k),
				.load_x   (load_position),
				.load_v   (load_velocity),
				.shift_in (sin),
				.q        (cell_q[k])
			);
		end
	endgenerate

	nlc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.stage     (stage_q),
		.first     (idx_q == '0),
		.has_right (CNT_W'(idx_q) + CNT_W'(1) < n),
		.head      (cell_q[0]),
		.nxt       (cell_q[(MAX_PARTICLES > 1) ? 1 : 0]),
		.coef      (coef_q),
		.done      (done),
		.wb        (wb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= 6'd8;
			coef_q.h     <= 32'sd838861;
			coef_q.kom   <= 32'sd167772160;
			coef_q.alpha <= 32'sd16777216;
			coef_q.beta  <= 32'sd8388608;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COUNT: count_q      <= cfg_data[5:0];
				REG_STEP:  coef_q.h     <= {1'b0, cfg_data[30:0]};
				REG_KOM:   coef_q.kom   <= {1'b0, cfg_data[30:0]};
				REG_ALPHA: coef_q.alpha <= cfg_data;
				REG_BETA:  coef_q.beta  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= T_IDLE;
			idx_q   <= '0;
			stage_q <= '0;
			strobe  <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (st_q)
				T_IDLE: begin
					idx_q   <= '0;
					stage_q <= '0;
					if (start && func == FUNC_STEP) st_q <= T_ISSUE;
					if (start && func == FUNC_REPORT) st_q <= T_EMIT;
				end
				T_ISSUE, T_WAIT: begin
					if (go) st_q <= T_WAIT;
					if (shift) begin
						idx_q <= last_slot ? '0 : idx_q + IDX_W'(1);
						st_q  <= T_ISSUE;
						if (last_slot) begin
							stage_q <= stage_q + 2'd1;
							if (stage_q == LAST_STAGE) st_q <= T_EMIT;
						end
					end
				end
				T_EMIT: begin
					strobe <= in_range;
					idx_q  <= last_slot ? '0 : idx_q + IDX_W'(1);
					if (last_slot) st_q <= T_IDLE;
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == T_IDLE) begin
			sp_q <= '0;
			sv_q <= '0;
		end else if (st_q == T_EMIT) begin
			sp_q          <= sp_n;
			sv_q          <= sv_n;
			out_index     <= 5'(idx_q);
			out_position  <= cell_q[0].x;
			out_velocity  <= cell_q[0].v;
			last_particle <= is_last;
			sum_position  <= is_last ? sp_n : '0;
			sum_velocity  <= is_last ? sv_n : '0;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/nlc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module nlc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic [1:0]         func,
	input wire logic               strobe,
	input wire logic [4:0]         out_index,
	input wire logic               last_particle,
	input wire logic signed [37:0] sum_position,
	input wire logic signed [37:0] sum_velocity
);
	import nlc_pkg::*;

	// results of one transaction come back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_particle |=> strobe)
		else $error("result burst broken");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_particle |=> out_index == 5'($past(out_index) + 5'd1))
		else $error("result index out of order");

	a_sums: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_particle |-> sum_position == '0 && sum_velocity == '0)
		else $error("sums nonzero before last result");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_LOAD |=> !strobe && !busy)
		else $error("load produced a result");

endmodule

bind nonlinear_chain_rk4_step nlc_checker u_nlc_checker (.*);
`default_nettype wire
